// ----- design/bdc_pkg.sv -----
// ----------------------------------------------------------------------------
// bdc_pkg - shared types and constants for the de Casteljau curve evaluator
// Beat layouts, the per-cell control struct and fixed field widths.
// ----------------------------------------------------------------------------
package bdc_pkg;

   // Field widths fixed by the interface
   localparam int COORD_BITS = 24;
   localparam int T_BITS     = 17;
   localparam int T_SHIFT    = 16;
   localparam int IDX_BITS   = 3;
   localparam int NP_BITS    = 4;
   localparam int PROD_BITS  = COORD_BITS + 1 + T_BITS + 1;

   localparam logic [T_BITS-1:0]  T_ONE            = 17'h10000;
   localparam logic [NP_BITS-1:0] NUM_POINTS_RESET = 4'd4;

   // Item kinds
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_EVAL = 1'b1;

   // Register indexes
   localparam int REG_NUM_POINTS = 0;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   typedef struct packed {
      logic                kind;
      logic [IDX_BITS-1:0] point_index;
      coord_type           point_x;
      coord_type           point_y;
      logic [T_BITS-1:0]   t_param;
   } req_type;

   typedef struct packed {
      coord_type curve_x;
      coord_type curve_y;
   } rsp_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic load;   // store the incoming control point
      logic copy;   // working point <= control point
      logic mul;    // capture the lerp products
      logic add;    // working point <= lerp result
   } cell_ctrl_type;

endpackage

// ----- design/bdc_lerp.sv -----
// ----------------------------------------------------------------------------
// bdc_lerp - one-coordinate linear interpolation
// r = p + floor((q - p) * t / 65536), product registered before the add.
// ----------------------------------------------------------------------------
module bdc_lerp (
   input  logic                      clock,
   input  logic                      mul_en,
   input  bdc_pkg::coord_type        p,
   input  bdc_pkg::coord_type        q,
   input  logic [bdc_pkg::T_BITS-1:0] t,
   output bdc_pkg::coord_type        r
);
   import bdc_pkg::*;

   logic signed [COORD_BITS:0]  diff;
   logic signed [PROD_BITS-1:0] prod_in;
   logic signed [PROD_BITS-1:0] prod_ff;
   logic signed [PROD_BITS-1:0] prod_shr;

   // difference and product, t taken as a non-negative signed value
   assign diff    = {q[COORD_BITS-1], q} - {p[COORD_BITS-1], p};
   assign prod_in = diff * $signed({1'b0, t});

   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= prod_in;
      end
   end

   // floor by arithmetic shift; the convex result always fits the coordinate
   assign prod_shr = prod_ff >>> T_SHIFT;
   assign r        = p + prod_shr[COORD_BITS-1:0];

endmodule

// ----- design/bdc_cell.sv -----
// ----------------------------------------------------------------------------
// bdc_cell - one slot of the interpolation row
// Holds a control point and a working point; each level it blends its own
// working point with its right-hand neighbour's.
// ----------------------------------------------------------------------------
module bdc_cell (
   input  logic                      clock,
   input  bdc_pkg::cell_ctrl_type    ctrl,
   input  bdc_pkg::coord_type        load_x,
   input  bdc_pkg::coord_type        load_y,
   input  bdc_pkg::coord_type        next_x,
   input  bdc_pkg::coord_type        next_y,
   input  logic [bdc_pkg::T_BITS-1:0] t,
   output bdc_pkg::coord_type        work_x,
   output bdc_pkg::coord_type        work_y
);
   import bdc_pkg::*;

   coord_type ctrl_x_ff, ctrl_y_ff;
   coord_type work_x_ff, work_y_ff;
   coord_type lerp_x, lerp_y;

   bdc_lerp u_lerp_x (
      .clock  (clock),
      .mul_en (ctrl.mul),
      .p      (work_x_ff),
      .q      (next_x),
      .t      (t),
      .r      (lerp_x)
   );

   bdc_lerp u_lerp_y (
      .clock  (clock),
      .mul_en (ctrl.mul),
      .p      (work_y_ff),
      .q      (next_y),
      .t      (t),
      .r      (lerp_y)
   );

   // control point store, undefined until loaded
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         ctrl_x_ff <= load_x;
         ctrl_y_ff <= load_y;
      end
   end

   // working point: seeded from the control point, then one level per add
   always_ff @(posedge clock) begin
      if (ctrl.copy) begin
         work_x_ff <= ctrl_x_ff;
         work_y_ff <= ctrl_y_ff;
      end else if (ctrl.add) begin
         work_x_ff <= lerp_x;
         work_y_ff <= lerp_y;
      end
   end

   assign work_x = work_x_ff;
   assign work_y = work_y_ff;

endmodule

// ----- design/bezier_de_casteljau_eval_core.sv -----
// ----------------------------------------------------------------------------
// bezier_de_casteljau_eval_core - 2-D Bezier curve evaluator
// Control points live in a row of cells; an evaluation reduces the row one
// de Casteljau level at a time, every cell blending with its neighbour.
//
//   channel   ports                         direction  handshake
//   request   start, busy, req_data         in         start & !busy
//   response  rsp_valid, rsp_data           out        one-cycle strobe
//   config    psel..pready, paddr, pwdata   in/out     APB, pready tied high
//
// A load beat leaves busy low. An evaluate beat copies the control points
// into the working points, then runs n-1 levels (n = points in use): each
// level is a multiply state then an add state in every cell.
// The result strobe comes with busy already low; the next beat may start then.
// Reset (synchronous) clears the sequencer and num_points to 4; stored
// points are undefined until loaded. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module bezier_de_casteljau_eval_core #(
   parameter int MAX_POINTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   // request
   input  logic             start,
   output logic             busy,
   input  bdc_pkg::req_type req_data,
   // response
   output logic             rsp_valid,
   output bdc_pkg::rsp_type rsp_data,
   // configuration
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [1:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import bdc_pkg::*;

   localparam int LVL_W = $clog2(MAX_POINTS);
   localparam int CNT_W = 6;
   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_POINTS);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_ADD} state_type;

   state_type            state_ff;
   logic                 rsp_valid_ff;
   logic [LVL_W-1:0]     lvl_ff;
   logic [T_BITS-1:0]    t_ff;
   logic [NP_BITS-1:0]   num_points_ff;

   logic                 accept;
   logic                 load_go;
   logic                 eval_go;
   logic [CNT_W-1:0]     np_ext;
   logic [CNT_W-1:0]     n_eff;
   logic [CNT_W-1:0]     lvl_init;
   logic [CNT_W-1:0]     idx_ext;
   logic [T_BITS-1:0]    t_in;
   logic                 csr_write;

   cell_ctrl_type        cell_ctrl [MAX_POINTS];
   coord_type            work_x [MAX_POINTS];
   coord_type            work_y [MAX_POINTS];

   // ------------------------------------------------------------------ APB
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr == 2'(REG_NUM_POINTS * 4)) ?
                      {{(32-NP_BITS){1'b0}}, num_points_ff} : '0;

   // single register; writes ignore the address
   always_ff @(posedge clock) begin
      if (reset) begin
         num_points_ff <= NUM_POINTS_RESET;
      end else if (csr_write) begin
         num_points_ff <= pwdata[NP_BITS-1:0];
      end
   end

   // ------------------------------------------------------------ decode
   assign busy    = (state_ff != ST_IDLE);
   assign accept  = start && !busy;
   assign idx_ext = {{(CNT_W-IDX_BITS){1'b0}}, req_data.point_index};
   assign load_go = accept && (req_data.kind == KIND_LOAD) && (idx_ext < MAX_N);
   assign eval_go = accept && (req_data.kind == KIND_EVAL);

   // points in use clamped to 1..MAX_POINTS; levels = points - 1
   assign np_ext   = {{(CNT_W-NP_BITS){1'b0}}, num_points_ff};
   assign n_eff    = (np_ext > MAX_N) ? MAX_N :
                     (np_ext == '0)   ? CNT_W'(1) : np_ext;
   assign lvl_init = n_eff - CNT_W'(1);

   // t above one acts as one
   assign t_in = (req_data.t_param > T_ONE) ? T_ONE : req_data.t_param;

   always_ff @(posedge clock) begin
      if (eval_go) begin
         t_ff <= t_in;
      end
   end

   // ------------------------------------------------------------ sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (eval_go) begin
                  lvl_ff <= lvl_init[LVL_W-1:0];
                  if (lvl_init == '0) begin
                     rsp_valid_ff <= 1'b1;
                  end else begin
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               state_ff <= ST_ADD;
            end
            ST_ADD: begin
               lvl_ff <= lvl_ff - LVL_W'(1);
               if (lvl_ff == LVL_W'(1)) begin
                  state_ff     <= ST_IDLE;
                  rsp_valid_ff <= 1'b1;
               end else begin
                  state_ff <= ST_MUL;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ------------------------------------------------------------ cell row
   // cells past the active count compute don't-care values that never
   // reach cell 0 within n-1 levels
   for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
      assign cell_ctrl[i].load = load_go && (idx_ext == CNT_W'(i));
      assign cell_ctrl[i].copy = eval_go;
      assign cell_ctrl[i].mul  = (state_ff == ST_MUL);
      assign cell_ctrl[i].add  = (state_ff == ST_ADD);

      if (i < MAX_POINTS - 1) begin : g_mid
         bdc_cell u_cell (
            .clock  (clock),
            .ctrl   (cell_ctrl[i]),
            .load_x (req_data.point_x),
            .load_y (req_data.point_y),
            .next_x (work_x[i+1]),
            .next_y (work_y[i+1]),
            .t      (t_ff),
            .work_x (work_x[i]),
            .work_y (work_y[i])
         );
      end else begin : g_last
         bdc_cell u_cell (
            .clock  (clock),
            .ctrl   (cell_ctrl[i]),
            .load_x (req_data.point_x),
            .load_y (req_data.point_y),
            .next_x (work_x[i]),
            .next_y (work_y[i]),
            .t      (t_ff),
            .work_x (work_x[i]),
            .work_y (work_y[i])
         );
      end
   end

   // ------------------------------------------------------------ response
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data.curve_x = work_x[0];
   assign rsp_data.curve_y = work_y[0];

   // ------------------------------------------------------------ checks
   // a result is only shown once the sequencer is free
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // a load never produces a result nor occupies the sequencer
   a_load_quiet: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.kind == KIND_LOAD) |=> (!rsp_valid && !busy))
      else $error("load beat raised a result or busy");

   // the final add level always ends in a result
   a_last_add_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD && lvl_ff == LVL_W'(1)) |=> rsp_valid)
      else $error("last level without result");

   // a multiply cycle is always followed by its add cycle
   a_mul_then_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |=> (state_ff == ST_ADD))
      else $error("multiply cycle not followed by add");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the de Casteljau curve evaluator
// Loads control points and evaluates curves over several point counts, with
// random gaps on the request side. Every evaluate beat is predicted by a
// software copy of the level-by-level reduction. Each strobed result is
// checked field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import bdc_pkg::*;

   localparam int SLOTS = 8;
   localparam coord_type C_MAX = 24'sh7FFFFF;
   localparam coord_type C_MIN = 24'sh800000;

   // Software copy of the evaluator plus the queue of curve points due
   class curve_checker;
      coord_type          ctrl_x [SLOTS];
      coord_type          ctrl_y [SLOTS];
      logic [NP_BITS-1:0] points_in_use;
      rsp_type            pending_points [$];
      int                 errors;

      function new();
         points_in_use = NUM_POINTS_RESET;
         errors        = 0;
      endfunction

      task report(input string what);
         errors++;
         if (errors <= 40)
            $display("ERROR at %0t ns: %s", $time, what);
      endtask

      function void set_points(input logic [NP_BITS-1:0] value);
         points_in_use = value;
      endfunction

      // floor((p*(1-t) + q*t)), t in Q1.16
      function coord_type blend(input coord_type p, input coord_type q, input longint t);
         longint acc;
         acc = longint'(p) * (longint'(65536) - t) + longint'(q) * t;
         return coord_type'(acc >>> T_SHIFT);
      endfunction

      function rsp_type eval_curve(input logic [T_BITS-1:0] t_raw);
         coord_type wx [SLOTS];
         coord_type wy [SLOTS];
         longint    t;
         int        n;
         rsp_type   pt;
         t = (t_raw > T_ONE) ? longint'(T_ONE) : longint'(t_raw);
         n = points_in_use;
         if (n > SLOTS) n = SLOTS;
         if (n < 1) n = 1;
         for (int j = 0; j < n; j++) begin
            wx[j] = ctrl_x[j];
            wy[j] = ctrl_y[j];
         end
         for (int lvl = 1; lvl < n; lvl++)
            for (int j = 0; j + lvl < n; j++) begin
               wx[j] = blend(wx[j], wx[j+1], t);
               wy[j] = blend(wy[j], wy[j+1], t);
            end
         pt.curve_x = wx[0];
         pt.curve_y = wy[0];
         return pt;
      endfunction

      function void note_item(input req_type item);
         if (item.kind == KIND_LOAD) begin
            if (item.point_index < SLOTS) begin
               ctrl_x[item.point_index] = item.point_x;
               ctrl_y[item.point_index] = item.point_y;
            end
         end else begin
            pending_points.push_back(eval_curve(item.t_param));
         end
      endfunction

      task check_point(input rsp_type got);
         rsp_type want;
         if (pending_points.size() == 0) begin
            report($sformatf("unexpected result x=%0d y=%0d", got.curve_x, got.curve_y));
         end else begin
            want = pending_points.pop_front();
            if (got.curve_x !== want.curve_x)
               report($sformatf("curve_x got %0d, want %0d", got.curve_x, want.curve_x));
            if (got.curve_y !== want.curve_y)
               report($sformatf("curve_y got %0d, want %0d", got.curve_y, want.curve_y));
         end
      endtask
   endclass

   // Clock, reset and block inputs, all known from time zero
   logic        clock   = 1'b0;
   logic        reset   = 1'b1;
   logic        start   = 1'b0;
   req_type     req_data = '0;
   logic        psel    = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite  = 1'b0;
   logic [1:0]  paddr   = '0;
   logic [31:0] pwdata  = '0;

   logic        busy;
   logic        rsp_valid;
   rsp_type     rsp_data;
   logic [31:0] prdata;
   logic        pready;

   logic        beat_taken = 1'b0;
   logic        csr_done   = 1'b0;

   curve_checker sb;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   bezier_de_casteljau_eval_core #(
      .MAX_POINTS (SLOTS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // Monitor: everything sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         beat_taken <= 1'b0;
         csr_done   <= 1'b0;
      end else begin
         beat_taken <= start && !busy;
         csr_done   <= psel && penable && pwrite && pready;
         if (rsp_valid)
            sb.check_point(rsp_data);
         if (psel && penable && pwrite && pready)
            sb.set_points(pwdata[NP_BITS-1:0]);
         if (start && !busy)
            sb.note_item(req_data);
      end
   end

   // Present one beat and hold it until taken; start is left high
   task automatic send_item(input req_type item);
      start    <= 1'b1;
      req_data <= item;
      do @(negedge clock); while (!beat_taken);
   endtask

   task automatic hold_off(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // Drain: nothing outstanding, then enough cycles for a full evaluation
   task automatic settle();
      start <= 1'b0;
      while (sb.pending_points.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   // Write the point count, then read it back while the address is held
   task automatic write_points_reg(input logic [NP_BITS-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= 2'(REG_NUM_POINTS * 4);
      pwdata  <= 32'(value);
      @(negedge clock);
      penable <= 1'b1;
      do @(negedge clock); while (!csr_done);
      if (prdata !== 32'(value))
         sb.report($sformatf("num_points read %0d, want %0d", prdata, value));
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   function automatic req_type mk_item(input logic kind, input int idx,
                                       input coord_type x, input coord_type y,
                                       input int t);
      req_type it;
      it.kind        = kind;
      it.point_index = IDX_BITS'(idx);
      it.point_x     = x;
      it.point_y     = y;
      it.t_param     = T_BITS'(t);
      return it;
   endfunction

   function automatic coord_type rand_coord();
      case ($urandom_range(0, 19))
         0:       return C_MAX;
         1:       return C_MIN;
         2:       return '0;
         3:       return '1;
         default: return coord_type'($urandom);
      endcase
   endfunction

   function automatic req_type rand_item(input int eval_pct);
      req_type it;
      int      r;
      it.kind        = ($urandom_range(0, 99) < eval_pct) ? KIND_EVAL : KIND_LOAD;
      it.point_index = IDX_BITS'($urandom_range(0, SLOTS - 1));
      it.point_x     = rand_coord();
      it.point_y     = rand_coord();
      r = $urandom_range(0, 99);
      if (r < 4)       it.t_param = '0;
      else if (r < 8)  it.t_param = T_ONE;
      else if (r < 10) it.t_param = T_BITS'(1);
      else if (r < 20) it.t_param = T_BITS'($urandom_range(0, 131071));
      else             it.t_param = T_BITS'($urandom_range(0, 65536));
      return it;
   endfunction

   // Mostly short gaps, now and then a long one
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Stimulus
   initial begin
      logic [NP_BITS-1:0] np;
      bit                 no_gaps;
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: every slot loaded first, so no evaluation reads an empty slot
      send_item(mk_item(KIND_LOAD, 0, C_MAX, C_MIN, 0));
      send_item(mk_item(KIND_LOAD, 1, C_MIN, C_MAX, 0));
      send_item(mk_item(KIND_LOAD, 2, '0, '1, 0));
      send_item(mk_item(KIND_LOAD, 3, '1, '0, 0));
      send_item(mk_item(KIND_LOAD, 4, C_MAX, C_MAX, 0));
      send_item(mk_item(KIND_LOAD, 5, C_MIN, C_MIN, 0));
      send_item(mk_item(KIND_LOAD, 6, 24'sh123456, -24'sh654321, 0));
      send_item(mk_item(KIND_LOAD, 7, -24'sh0000FF, 24'sh3C3C3C, 0));
      // Point count at its reset value; t at both ends, mid, edges and above one
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 0));
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 65536));
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 32768));
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 1));
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 65535));
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 131071));
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 65537));
      // Point count extremes, including too few and too many
      settle();
      write_points_reg(4'd2);
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 65535));
      settle();
      write_points_reg(4'd8);
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 1));
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 40000));
      settle();
      write_points_reg(4'd0);
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 12345));
      settle();
      write_points_reg(4'd1);
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 50000));
      settle();
      write_points_reg(4'd15);
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 30000));
      settle();
      write_points_reg(4'd9);
      send_item(mk_item(KIND_EVAL, 0, '0, '0, 20000));

      // Random phases, each at its own point count
      for (int ph = 0; ph < 7; ph++) begin
         if (ph == 0)
            np = 4'd8;
         else if (ph == 1)
            np = 4'd2;
         else if ($urandom_range(0, 3) == 0)
            np = NP_BITS'($urandom_range(0, 15));
         else
            np = NP_BITS'($urandom_range(2, 8));
         no_gaps = (ph == 2) || ($urandom_range(0, 5) == 0);
         settle();
         write_points_reg(np);
         for (int k = 0; k < 64; k++) begin
            send_item(rand_item(65));
            if (!no_gaps)
               hold_off(gap_len());
         end
      end

      // Drain and give the block time to show any stray strobe
      settle();
      if (sb.errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Watchdog
   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
